@@ rtl/core/tsmc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Timed shutter motor controller package
// Codes, item layouts and control-state type shared by the controller files.
// ----------------------------------------------------------------------------
package tsmc_pkg;

  // Configuration registers are all this wide.
  localparam int CFG_WIDTH       = 16;
  localparam int CFG_INDEX_WIDTH = 1;

  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_TRAVEL_UP   = 1'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_TRAVEL_DOWN = 1'd1;

  typedef enum logic [2:0] {
    OP_TICK       = 3'd0,
    OP_REQ_OPEN   = 3'd1,
    OP_REQ_CLOSE  = 3'd2,
    OP_REQ_STOP   = 3'd3,
    OP_TRIGGER    = 3'd4,
    OP_RESTORE    = 3'd5
  } opcode_t;

  typedef enum logic [2:0] {
    ST_CLOSED  = 3'd0,
    ST_CLOSING = 3'd1,
    ST_OPEN    = 3'd2,
    ST_OPENING = 3'd3,
    ST_STOPPED = 3'd4
  } shutter_state_t;

  typedef enum logic [1:0] {
    CMD_RAISE = 2'd0,
    CMD_LOWER = 2'd1,
    CMD_HALT  = 2'd2,
    CMD_NONE  = 2'd3
  } command_t;

  typedef struct packed {
    logic [2:0] opcode;
    logic [2:0] restore_state;
    logic [1:0] restore_command;
  } item_t;

  typedef struct packed {
    logic       motor_on;
    logic       move_up;
    logic [2:0] shutter_state;
    logic [1:0] executed_command;
    logic       report_valid;
    logic       trigger_pending;
  } result_t;

  // Control state of the controller, apart from the travel timer.
  typedef struct packed {
    shutter_state_t state;
    command_t       wanted;
    command_t       done;
    logic           pending;
    logic           trig;
    logic           moving;
    logic           going_up;
  } ctrl_t;

endpackage
`default_nettype wire

@@ rtl/core/tsmc_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Timed shutter motor controller channels
// Valid/ready channels for event requests in and status results out.
// ----------------------------------------------------------------------------
interface tsmc_item_if;
  import tsmc_pkg::*;

  logic  valid;
  logic  ready;
  item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tsmc_result_if;
  import tsmc_pkg::*;

  logic    valid;
  logic    ready;
  result_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/core/tsmc_step.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Timed shutter motor controller step
// Applies one event to the control state, then runs command execution and
// the travel timeout check.
// ----------------------------------------------------------------------------
module tsmc_step #(
  parameter int TIMER_WIDTH = 16
) (
  input  tsmc_pkg::item_t                   item,
  input  tsmc_pkg::ctrl_t                   ctrl,
  input  logic [TIMER_WIDTH:0]              elapsed,
  input  logic [tsmc_pkg::CFG_WIDTH-1:0]    travel_up,
  input  logic [tsmc_pkg::CFG_WIDTH-1:0]    travel_down,
  output tsmc_pkg::ctrl_t                   ctrl_next,
  output logic [TIMER_WIDTH:0]              elapsed_next,
  output logic                              report
);
  import tsmc_pkg::*;

  localparam int EW   = TIMER_WIDTH + 1;
  localparam int LIMW = (TIMER_WIDTH < CFG_WIDTH) ? TIMER_WIDTH : CFG_WIDTH;

  logic [EW-1:0] limit;

  always_comb begin
    ctrl_next    = ctrl;
    elapsed_next = elapsed;
    report       = 1'b0;
    limit        = '0;

    case (item.opcode)
      OP_TICK: begin
        if (elapsed != {EW{1'b1}}) begin
          elapsed_next = elapsed + EW'(1);
        end
      end
      OP_REQ_OPEN: begin
        if (ctrl.done != CMD_RAISE) begin
          ctrl_next.wanted  = CMD_RAISE;
          ctrl_next.pending = 1'b1;
        end
      end
      OP_REQ_CLOSE: begin
        if (ctrl.done != CMD_LOWER) begin
          ctrl_next.wanted  = CMD_LOWER;
          ctrl_next.pending = 1'b1;
        end
      end
      OP_REQ_STOP: begin
        if (ctrl.done != CMD_HALT) begin
          ctrl_next.wanted  = CMD_HALT;
          ctrl_next.pending = 1'b1;
        end
      end
      OP_TRIGGER: begin
        ctrl_next.trig = 1'b1;
      end
      OP_RESTORE: begin
        // Saved states beyond the known set come back as stopped.
        if (item.restore_state > 3'(ST_STOPPED)) begin
          ctrl_next.state = ST_STOPPED;
        end else begin
          ctrl_next.state = shutter_state_t'(item.restore_state);
        end
        ctrl_next.wanted   = command_t'(item.restore_command);
        ctrl_next.done     = command_t'(item.restore_command);
        ctrl_next.pending  = 1'b0;
        ctrl_next.trig     = 1'b0;
        ctrl_next.moving   = 1'b0;
        ctrl_next.going_up = 1'b1;
        elapsed_next       = '0;
      end
      default: begin
      end
    endcase

    if (ctrl_next.pending && ctrl_next.trig) begin
      ctrl_next.pending = 1'b0;
      ctrl_next.trig    = 1'b0;
      case (ctrl_next.wanted)
        CMD_RAISE: begin
          ctrl_next.state    = ST_OPENING;
          ctrl_next.moving   = 1'b1;
          ctrl_next.going_up = 1'b1;
          elapsed_next       = '0;
          report             = 1'b1;
        end
        CMD_LOWER: begin
          ctrl_next.state    = ST_CLOSING;
          ctrl_next.moving   = 1'b1;
          ctrl_next.going_up = 1'b0;
          elapsed_next       = '0;
          report             = 1'b1;
        end
        CMD_HALT: begin
          ctrl_next.state    = ST_STOPPED;
          ctrl_next.moving   = 1'b0;
          ctrl_next.going_up = 1'b1;
          report             = 1'b1;
        end
        default: begin
        end
      endcase
      ctrl_next.done = ctrl_next.wanted;
    end

    if (ctrl_next.going_up) begin
      limit = EW'(travel_up[LIMW-1:0]);
    end else begin
      limit = EW'(travel_down[LIMW-1:0]);
    end

    if (ctrl_next.moving && (elapsed_next > limit)) begin
      if (ctrl_next.state == ST_OPENING) begin
        ctrl_next.state = ST_OPEN;
      end else if (ctrl_next.state == ST_CLOSING) begin
        ctrl_next.state = ST_CLOSED;
      end
      ctrl_next.moving   = 1'b0;
      ctrl_next.going_up = 1'b1;
      report             = 1'b1;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/timed_shutter_motor_controller_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// A request accepted into the input register is applied by the step when the
// result register is free or being emptied, and its result is registered there.
// Throughput: one request per cycle while the receiver keeps taking results.
// Reset (rst, synchronous, active high) empties both registers, clears the
// travel times to zero and puts the shutter in the closed state, no command.
// ----------------------------------------------------------------------------
// Timed shutter motor controller
// Latches open/close/stop requests, runs them on a trigger and stops the
// motor once the travel time for its direction has passed.
// ----------------------------------------------------------------------------
module timed_shutter_motor_controller_top #(
  parameter int TIMER_WIDTH = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_write,
  input  logic [tsmc_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
  input  logic [tsmc_pkg::CFG_WIDTH-1:0]         cfg_data,
  tsmc_item_if.sink                              item,
  tsmc_result_if.source                          result
);
  import tsmc_pkg::*;

  // Travel times in timer ticks; only the low TIMER_WIDTH bits take part in
  // the timeout compare.
  logic [CFG_WIDTH-1:0] travel_up;
  logic [CFG_WIDTH-1:0] travel_down;

  // Input register: holds one accepted request until the step consumes it.
  logic  in_valid;
  item_t in_item;

  // Controller state. The reported state of the original controller always
  // equals the current state, so only the latter is kept.
  ctrl_t                ctrl;
  ctrl_t                ctrl_next;
  logic [TIMER_WIDTH:0] elapsed;
  logic [TIMER_WIDTH:0] elapsed_next;
  logic                 report;

  // Result register.
  logic    out_valid;
  result_t out_data;

  logic advance;

  // The step fires whenever the input register holds a request and the result
  // register is free or being emptied, and the input register reloads in the same
  // cycle, so requests flow at one per cycle while the receiver keeps up.
  assign advance     = in_valid && (!out_valid || result.ready);
  assign item.ready  = !in_valid || advance;
  assign result.valid = out_valid;
  assign result.data  = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      travel_up   <= '0;
      travel_down <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_TRAVEL_UP:   travel_up   <= cfg_data;
        CFG_TRAVEL_DOWN: travel_down <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (item.valid && item.ready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      in_item <= item.data;
    end
  end

  tsmc_step #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_step (
    .item         (in_item),
    .ctrl         (ctrl),
    .elapsed      (elapsed),
    .travel_up    (travel_up),
    .travel_down  (travel_down),
    .ctrl_next    (ctrl_next),
    .elapsed_next (elapsed_next),
    .report       (report)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl.state    <= ST_CLOSED;
      ctrl.wanted   <= CMD_NONE;
      ctrl.done     <= CMD_NONE;
      ctrl.pending  <= 1'b0;
      ctrl.trig     <= 1'b0;
      ctrl.moving   <= 1'b0;
      ctrl.going_up <= 1'b1;
      elapsed       <= '0;
    end else if (advance) begin
      ctrl    <= ctrl_next;
      elapsed <= elapsed_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  // The status reflects the state after the request has been applied.
  always_ff @(posedge clk) begin
    if (advance) begin
      out_data.motor_on         <= ctrl_next.moving;
      out_data.move_up          <= ctrl_next.going_up;
      out_data.shutter_state    <= ctrl_next.state;
      out_data.executed_command <= ctrl_next.done;
      out_data.report_valid     <= report;
      out_data.trigger_pending  <= ctrl_next.trig;
    end
  end

  // A running motor always belongs to an opening or closing travel.
  a_moving_state : assert property (@(posedge clk) disable iff (rst)
    ctrl.moving |-> (ctrl.state == ST_OPENING || ctrl.state == ST_CLOSING))
    else $error("motor running outside a travel state");

  // The direction relay rests in the upward position whenever the motor is off.
  a_idle_up : assert property (@(posedge clk) disable iff (rst)
    !ctrl.moving |-> ctrl.going_up)
    else $error("direction relay not released while idle");

  // Downward motion only while closing.
  a_down_closing : assert property (@(posedge clk) disable iff (rst)
    (ctrl.moving && !ctrl.going_up) |-> (ctrl.state == ST_CLOSING))
    else $error("downward motion outside closing");

  // A latched trigger and a pending command are consumed together.
  a_no_stale_pair : assert property (@(posedge clk) disable iff (rst)
    !(ctrl.pending && ctrl.trig))
    else $error("pending command left beside a latched trigger");

  // Control state only changes when a request is processed.
  a_state_hold : assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(ctrl))
    else $error("control state changed without a request");

endmodule
`default_nettype wire

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shutter controller testbench
// Drives tick, request, trigger and restore events into the timed shutter
// controller and checks every status result against a cycle-free model of
// the controller kept inside the bench. The run covers short directed
// sequences, the extremes of both travel times, random traffic under several
// idling patterns, a long receiver hold-off and a full drain mid-stream.
// ----------------------------------------------------------------------------
module tb_top;
  import tsmc_pkg::*;

  // The controller is built with the default timer width; the model follows.
  localparam int TIMER_WIDTH = 16;
  localparam logic [TIMER_WIDTH:0] ELAPSED_MAX = '1;
  // Far beyond the slowest correct run, even under the heaviest stalls and the
  // long receiver hold-off.
  localparam int CYCLE_LIMIT = 50_000;
  localparam int MAX_REPORTED = 10;

  logic clk = 1'b0;
  logic rst;
  logic cfg_write;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index;
  logic [CFG_WIDTH-1:0] cfg_data;

  tsmc_item_if item_ch ();
  tsmc_result_if result_ch ();

  timed_shutter_motor_controller_top #(
    .TIMER_WIDTH(TIMER_WIDTH)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .item     (item_ch),
    .result   (result_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Model of the controller. Only the monitor process below touches it, so
  // the model state advances exactly once per accepted request, in order.
  // --------------------------------------------------------------------------
  logic [CFG_WIDTH-1:0] up_ticks;
  logic [CFG_WIDTH-1:0] down_ticks;
  shutter_state_t shutter;
  shutter_state_t reported;
  command_t wanted_cmd;
  command_t done_cmd;
  logic pend;
  logic trig;
  logic running;
  logic dir_up;
  logic [TIMER_WIDTH:0] elapsed;

  // Status results the controller still owes us, oldest first.
  result_t status_due[$];

  int mismatches = 0;
  int items_sent = 0;
  int statuses_checked = 0;
  int reports_seen = 0;

  // A request for the command that already ran last is simply dropped.
  function automatic void note_request(input command_t cmd);
    if (done_cmd != cmd) begin
      wanted_cmd = cmd;
      pend = 1'b1;
    end
  endfunction

  // Applies one event, then the controller step: a pending command runs if a
  // trigger is latched, and then the travel timeout is checked.
  function automatic result_t advance_shutter(input item_t it);
    result_t r;
    logic report;
    logic [TIMER_WIDTH-1:0] limit;
    report = 1'b0;
    case (it.opcode)
      OP_TICK: begin
        // The elapsed count saturates rather than wrapping, and runs even
        // while the motor is idle.
        if (elapsed != ELAPSED_MAX) elapsed = elapsed + 1'b1;
      end
      OP_REQ_OPEN:  note_request(CMD_RAISE);
      OP_REQ_CLOSE: note_request(CMD_LOWER);
      OP_REQ_STOP:  note_request(CMD_HALT);
      OP_TRIGGER:   trig = 1'b1;
      OP_RESTORE: begin
        // Saved states beyond the last legal code come back as stopped.
        shutter = (it.restore_state > ST_STOPPED) ? ST_STOPPED
                                                  : shutter_state_t'(it.restore_state);
        reported = shutter;
        wanted_cmd = command_t'(it.restore_command);
        done_cmd = command_t'(it.restore_command);
        pend = 1'b0;
        trig = 1'b0;
        elapsed = '0;
        running = 1'b0;
        dir_up = 1'b1;
      end
      default: ;  // the two spare opcodes carry no event
    endcase

    if (pend && trig) begin
      trig = 1'b0;
      pend = 1'b0;
      case (wanted_cmd)
        CMD_RAISE: begin
          shutter = ST_OPENING;
          reported = shutter;
          report = 1'b1;
          running = 1'b1;
          dir_up = 1'b1;
          elapsed = '0;
        end
        CMD_LOWER: begin
          shutter = ST_CLOSING;
          reported = shutter;
          report = 1'b1;
          running = 1'b1;
          dir_up = 1'b0;
          elapsed = '0;
        end
        CMD_HALT: begin
          shutter = ST_STOPPED;
          reported = shutter;
          report = 1'b1;
          running = 1'b0;
          dir_up = 1'b1;
        end
        default: ;
      endcase
      done_cmd = wanted_cmd;
    end

    if (running) begin
      limit = dir_up ? up_ticks[TIMER_WIDTH-1:0] : down_ticks[TIMER_WIDTH-1:0];
      if (elapsed > limit) begin
        // A timeout outside opening or closing keeps the state but still
        // stops the motor and reports.
        if (reported == ST_OPENING) shutter = ST_OPEN;
        else if (reported == ST_CLOSING) shutter = ST_CLOSED;
        reported = shutter;
        report = 1'b1;
        running = 1'b0;
        dir_up = 1'b1;
      end
    end

    r.motor_on = running;
    r.move_up = dir_up;
    r.shutter_state = shutter;
    r.executed_command = done_cmd;
    r.report_valid = report;
    r.trigger_pending = trig;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Monitor: on each rising edge it first checks a delivered status result
  // against the oldest expectation, then takes any register write and any
  // accepted request into the model. A result can never belong to a request
  // accepted at the same edge, so this order is safe.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    result_t want;
    if (rst) begin
      up_ticks = '0;
      down_ticks = '0;
      shutter = ST_CLOSED;
      reported = ST_CLOSED;
      wanted_cmd = CMD_NONE;
      done_cmd = CMD_NONE;
      pend = 1'b0;
      trig = 1'b0;
      running = 1'b0;
      dir_up = 1'b1;
      elapsed = '0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        statuses_checked++;
        if (status_due.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTED)
            $display("[%0t] unexpected status result: motor %b up %b state %0d cmd %0d report %b trig %b",
                     $realtime, result_ch.data.motor_on, result_ch.data.move_up,
                     result_ch.data.shutter_state, result_ch.data.executed_command,
                     result_ch.data.report_valid, result_ch.data.trigger_pending);
        end else begin
          want = status_due.pop_front();
          if (want.report_valid) reports_seen++;
          if (result_ch.data.motor_on !== want.motor_on ||
              result_ch.data.move_up !== want.move_up ||
              result_ch.data.shutter_state !== want.shutter_state ||
              result_ch.data.executed_command !== want.executed_command ||
              result_ch.data.report_valid !== want.report_valid ||
              result_ch.data.trigger_pending !== want.trigger_pending) begin
            mismatches++;
            if (mismatches <= MAX_REPORTED) begin
              $display("[%0t] status mismatch on result %0d", $realtime, statuses_checked);
              $display("  expected motor %b up %b state %0d cmd %0d report %b trig %b",
                       want.motor_on, want.move_up, want.shutter_state,
                       want.executed_command, want.report_valid, want.trigger_pending);
              $display("  actual   motor %b up %b state %0d cmd %0d report %b trig %b",
                       result_ch.data.motor_on, result_ch.data.move_up,
                       result_ch.data.shutter_state, result_ch.data.executed_command,
                       result_ch.data.report_valid, result_ch.data.trigger_pending);
            end
          end
        end
      end

      if (cfg_write) begin
        case (cfg_index)
          CFG_TRAVEL_UP:   up_ticks = cfg_data;
          CFG_TRAVEL_DOWN: down_ticks = cfg_data;
          default: ;
        endcase
      end

      if (item_ch.valid && item_ch.ready)
        status_due.push_back(advance_shutter(item_ch.data));
    end
  end

  // Watchdog: a hung handshake must not leave the run spinning for ever.
  int cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycle_count, status_due.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Receiver side. Ready changes only on the falling edge. The stall rate is
  // set per phase; while a hold-off is running, ready stays low throughout.
  // --------------------------------------------------------------------------
  int gap_pct = 0;
  int stall_pct = 0;
  logic holding = 1'b0;

  initial begin
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (holding) result_ch.ready = 1'b0;
      else result_ch.ready = ($urandom_range(99) >= stall_pct);
    end
  end

  // The hold-off is timed in its own process. The flag changes on the rising
  // edge, so the receiver never races it on the falling edge.
  task automatic hold_receiver(input int cycles);
    @(posedge clk);
    holding = 1'b1;
    repeat (cycles) @(posedge clk);
    holding = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Sender side. Valid and data change only on the falling edge. After a
  // request is taken, valid stays high so that the next call can offer its
  // request straight away; item_idle lowers it when the stream pauses.
  // --------------------------------------------------------------------------
  task automatic send_item(input item_t it);
    @(negedge clk);
    while ($urandom_range(99) < gap_pct) begin
      item_ch.valid = 1'b0;
      @(negedge clk);
    end
    item_ch.valid = 1'b1;
    item_ch.data = it;
    do @(posedge clk); while (!item_ch.ready);
    items_sent++;
  endtask

  // Any event by opcode; the restore fields get random values so that all their
  // bits toggle, and they matter only if the opcode is a restore.
  task automatic send_op(input logic [2:0] op);
    item_t it;
    it.opcode = op;
    it.restore_state = 3'($urandom);
    it.restore_command = 2'($urandom);
    send_item(it);
  endtask

  task automatic send_restore(input logic [2:0] saved_state, input logic [1:0] saved_cmd);
    item_t it;
    it.opcode = OP_RESTORE;
    it.restore_state = saved_state;
    it.restore_command = saved_cmd;
    send_item(it);
  endtask

  task automatic item_idle();
    @(negedge clk);
    item_ch.valid = 1'b0;
  endtask

  // Stops offering and waits until every owed status result has come back.
  // Every request produces exactly one result, so an empty queue means the
  // controller is idle.
  task automatic wait_drained();
    item_idle();
    while (status_due.size() != 0) @(negedge clk);
  endtask

  task automatic write_travel(input logic [CFG_INDEX_WIDTH-1:0] idx,
                              input logic [CFG_WIDTH-1:0] value);
    wait_drained();
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  // One random stretch: mostly a well-formed command (request, sometimes a
  // change of mind, the trigger, then zero to ten ticks, which may or may not
  // pass the travel limit), with the rest plain noise including restores and
  // the two spare opcodes.
  task automatic play_sequence();
    int n;
    if ($urandom_range(99) < 75) begin
      send_op(3'($urandom_range(OP_REQ_STOP, OP_REQ_OPEN)));
      if ($urandom_range(3) == 0) send_op(3'($urandom_range(OP_REQ_STOP, OP_REQ_OPEN)));
      send_op(OP_TRIGGER);
      n = $urandom_range(10);
      repeat (n) send_op(OP_TICK);
    end else begin
      n = $urandom_range(1, 4);
      repeat (n) begin
        if ($urandom_range(3) == 0)
          send_restore(3'($urandom), 2'($urandom));
        else
          send_op(3'($urandom_range(7)));
      end
    end
  endtask

  task automatic random_traffic(input int count);
    int start;
    start = items_sent;
    while (items_sent - start < count) play_sequence();
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Hand-picked walk through every event kind and the corner cases: a
  // trigger with nothing pending, a repeated request being dropped, reversal
  // while moving, stop, the spare opcodes and restores including an
  // out-of-range saved state.
  task automatic test_directed();
    write_travel(CFG_TRAVEL_UP, 16'd3);
    write_travel(CFG_TRAVEL_DOWN, 16'd2);
    gap_pct = 0;
    stall_pct = 0;
    send_op(OP_TICK);          // tick while idle still counts
    send_op(OP_TRIGGER);       // trigger latched with nothing to run
    send_op(OP_REQ_OPEN);      // runs at once on the latched trigger
    repeat (4) send_op(OP_TICK);  // the fourth tick passes the up limit
    send_op(OP_REQ_OPEN);      // same as the last command, so dropped
    send_op(OP_REQ_CLOSE);
    send_op(3'd6);
    send_op(OP_TRIGGER);
    send_op(OP_TICK);
    send_op(OP_REQ_OPEN);      // reverse while still closing
    send_op(OP_TRIGGER);
    send_op(OP_REQ_STOP);
    send_op(OP_TRIGGER);
    send_op(OP_REQ_STOP);      // dropped: stop has just run
    send_op(3'd7);
    send_restore(3'd7, CMD_NONE);
    send_restore(ST_OPENING, CMD_RAISE);
    send_restore(ST_CLOSING, CMD_LOWER);
    send_op(OP_REQ_CLOSE);     // dropped after the restored close
    send_op(OP_REQ_OPEN);
    send_op(OP_TRIGGER);
    wait_drained();
  endtask

  // Both travel times at zero, where a single tick completes the travel, then
  // both at their maximum, where a run of ticks leaves the motor running in
  // either direction until a reversal and a stop end it.
  task automatic test_travel_extremes();
    gap_pct = 0;
    stall_pct = 0;
    write_travel(CFG_TRAVEL_UP, 16'd0);
    write_travel(CFG_TRAVEL_DOWN, 16'd0);
    send_restore(ST_CLOSED, CMD_NONE);
    send_op(OP_REQ_OPEN);
    send_op(OP_TRIGGER);
    send_op(OP_TICK);
    send_op(OP_REQ_CLOSE);
    send_op(OP_TRIGGER);
    send_op(OP_TICK);
    write_travel(CFG_TRAVEL_UP, 16'hFFFF);
    write_travel(CFG_TRAVEL_DOWN, 16'hFFFF);
    send_op(OP_REQ_OPEN);
    send_op(OP_TRIGGER);
    repeat (20) send_op(OP_TICK);
    send_op(OP_REQ_CLOSE);
    send_op(OP_TRIGGER);
    repeat (10) send_op(OP_TICK);
    send_op(OP_REQ_STOP);
    send_op(OP_TRIGGER);
    wait_drained();
  endtask

  // Random traffic under each idling pattern, with fresh small travel times
  // for every phase so that commands complete within a few ticks.
  task automatic test_random_phases();
    int pattern[4][2] = '{'{0, 0}, '{51, 0}, '{0, 51}, '{12, 12}};
    foreach (pattern[p]) begin
      write_travel(CFG_TRAVEL_UP, 16'($urandom_range(8)));
      write_travel(CFG_TRAVEL_DOWN, 16'($urandom_range(8)));
      gap_pct = pattern[p][0];
      stall_pct = pattern[p][1];
      random_traffic(115);
    end
    wait_drained();
  endtask

  // The receiver holds off while the sender keeps offering, so the controller
  // fills up and has to stall its input.
  task automatic test_backpressure();
    gap_pct = 0;
    stall_pct = 0;
    fork
      hold_receiver(300);
      random_traffic(80);
    join
    wait_drained();
  endtask

  // The sender stops mid-stream until every result is back, then carries on.
  task automatic test_drain_pause();
    gap_pct = 12;
    stall_pct = 12;
    random_traffic(40);
    wait_drained();
    random_traffic(40);
    wait_drained();
  endtask

  initial begin
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    item_ch.valid = 1'b0;
    item_ch.data = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_travel_extremes();
    test_random_phases();
    test_backpressure();
    test_drain_pause();

    // Leave a margin for any stray result to show up as an unexpected one.
    wait_drained();
    repeat (8) @(posedge clk);

    $display("Ran %0d requests over directed, travel-extreme, random and back-pressure phases.",
             items_sent);
    $display("Checked %0d status results, %0d of them carrying a state report; %0d mismatches.",
             statuses_checked, reports_seen, mismatches);
    if (mismatches == 0 && status_due.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/tsmc_pkg.sv
rtl/core/tsmc_if.sv
rtl/core/tsmc_step.sv
rtl/core/timed_shutter_motor_controller_top.sv
verif/tb_top.sv
